// ----- rtl/fca_pkg.sv -----
package fca_pkg;

  // Default size of the FAT byte store.
  localparam int unsigned FAT_TABLE_BYTES_DEF = 8192;

  // Byte offsets are kept one bit wider than the largest store so that an
  // offset can be compared against the store size.
  localparam int unsigned OFF_W = 14;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned DIR_ENTRY_BYTES = 32;
  localparam int unsigned ROOT_SHIFT      = $clog2(SECTOR_BYTES / DIR_ENTRY_BYTES);

  localparam logic [11:0] ENTRY_MASK = 12'hFFF;
  localparam logic [11:0] EOC_MASK   = 12'hFF0;

  // Serial divider widths: a 20-bit dividend and a 14-bit divisor that holds
  // either sectors_per_track or head_count.
  localparam int unsigned QUO_W  = 20;
  localparam int unsigned DIVS_W = 14;
  localparam int unsigned CNT_W  = $clog2(QUO_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESERVED_SECTORS    = 3'd0,
    REG_FAT_SECTORS         = 3'd1,
    REG_FAT_COUNT           = 3'd2,
    REG_ROOT_ENTRIES        = 3'd3,
    REG_SECTORS_PER_CLUSTER = 3'd4,
    REG_SECTORS_PER_TRACK   = 3'd5,
    REG_HEAD_COUNT          = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_FOLLOW = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_HI,
    S_ENTRY,
    S_SUM,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_DONE
  } fca_state_e;

  typedef struct packed {
    logic        op;
    logic [12:0] byte_address;
    logic [7:0]  byte_value;
    logic [11:0] cluster;
  } in_word_t;

  typedef struct packed {
    logic [11:0] next_cluster;
    logic        end_of_chain;
    logic        bad_cluster;
    logic [19:0] logical_sector;
    logic [19:0] track;
    logic        head;
    logic [5:0]  sector;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [QUO_W-1:0]  dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUO_W-1:0]  quotient;
    logic [DIVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/fca_fat_store.sv -----
module fca_fat_store #(
  parameter int unsigned DEPTH = fca_pkg::FAT_TABLE_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fca_divider.sv -----
module fca_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fca_pkg::div_req_t  req_i,
  output fca_pkg::div_rsp_t  rsp_o
);
  import fca_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] divisor_q, divisor_d;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // Restoring division: one quotient bit per cycle, dividend shifted out
  // of the quotient register MSB first.
  always_comb begin
    trial = {rem_q, quo_q[QUO_W-1]};
    diff  = trial - {1'b0, divisor_q};
    ge    = (trial >= {1'b0, divisor_q});
  end

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start && !busy_q) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      quo_d     = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[QUO_W-2:0], ge};
      rem_d = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- rtl/fat12_cluster_chain_address.sv -----
// FAT12 cluster chain lookup with sector and floppy address translation.
// Input channel (in_valid_i / in_stall_o / in_i): a word with op 0 stores
// byte_value at byte_address of the internal FAT table; a word with op 1
// looks up the FAT entry of cluster and translates a cluster of 2 or more
// into a 1-based logical sector and a track / head / sector address.
// Output channel (out_valid_o / out_stall_i / out_o): exactly one result
// word per input word, in order. A write gives an all-zero result.
// Configuration: cfg_we_i writes cfg_data_i into the register selected by
// cfg_index_i; write only while no word is in flight.
// Sequence: a write goes straight to the final state. A follow reads two
// FAT bytes through the table's read port and, for a cluster of 2 or
// more, then makes two passes of one bit-serial divider (first by
// sectors_per_track, then by head_count). Input is stalled while a word
// is in work, so no new word is taken until the last one is finished.
// The result sits in an output register, so a stalled receiver does not
// keep the next word from being accepted; only a finished result that
// finds the output register still full waits for it.
// Reset restores the default geometry; the FAT table content is undefined
// until written.
module fat12_cluster_chain_address #(
  parameter int unsigned FAT_TABLE_BYTES = fca_pkg::FAT_TABLE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fca_pkg::in_word_t                  in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fca_pkg::out_word_t                 out_o,
  input  logic                               cfg_we_i,
  input  logic [fca_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fca_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import fca_pkg::*;

  localparam int unsigned AW = $clog2(FAT_TABLE_BYTES);
  localparam logic [OFF_W-1:0] TABLE_END = OFF_W'(FAT_TABLE_BYTES);

  // Configuration registers.
  logic [7:0]  reserved_q;
  logic [4:0]  fat_sectors_q;
  logic [2:0]  fat_count_q;
  logic [11:0] root_entries_q;
  logic [7:0]  spc_q;
  logic [5:0]  spt_q;
  logic [7:0]  heads_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q     <= 8'd0;
      fat_sectors_q  <= 5'd9;
      fat_count_q    <= 3'd2;
      root_entries_q <= 12'd224;
      spc_q          <= 8'd1;
      spt_q          <= 6'd18;
      heads_q        <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RESERVED_SECTORS:    reserved_q     <= cfg_data_i[7:0];
        REG_FAT_SECTORS:         fat_sectors_q  <= cfg_data_i[4:0];
        REG_FAT_COUNT:           fat_count_q    <= cfg_data_i[2:0];
        REG_ROOT_ENTRIES:        root_entries_q <= cfg_data_i[11:0];
        REG_SECTORS_PER_CLUSTER: spc_q          <= cfg_data_i[7:0];
        REG_SECTORS_PER_TRACK:   spt_q          <= cfg_data_i[5:0];
        REG_HEAD_COUNT:          heads_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  fca_state_e       state_q, state_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        res_q, res_d;
  out_word_t        out_q, out_d;
  logic [11:0]      cl_q, cl_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic             oor_q;
  logic [7:0]       lo_q, lo_d;
  logic [19:0]      prod_q, prod_d;
  logic [9:0]       startm1_q, startm1_d;
  logic [19:0]      z_q, z_d;

  logic             in_accept;
  logic             mem_we;
  logic [OFF_W-1:0] rd_off;
  logic [7:0]       rd_data;
  logic [7:0]       rd_byte;
  logic [15:0]      fat_word;
  logic [11:0]      entry;
  logic [5:0]       spt_eff;
  logic [7:0]       heads_eff;
  logic [11:0]      cl_rel;
  logic [20:0]      z_sum;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign mem_we     = in_accept && (in_i.op == OP_WRITE)
                      && ({1'b0, in_i.byte_address} < TABLE_END);

  assign spt_eff   = (spt_q == '0) ? 6'd1 : spt_q;
  assign heads_eff = (heads_q == '0) ? 8'd1 : heads_q;

  // The first FAT byte of a cluster sits at cluster*3/2.
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_off = OFF_W'(in_i.cluster) + OFF_W'(in_i.cluster[11:1]);
    end else begin
      rd_off = off_q + OFF_W'(1);
    end
  end

  fca_fat_store #(
    .DEPTH (FAT_TABLE_BYTES)
  ) u_fat_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_i.byte_address[AW-1:0]),
    .wdata_i (in_i.byte_value),
    .raddr_i (rd_off[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Bytes past the end of the table read as zero.
  assign rd_byte  = oor_q ? 8'd0 : rd_data;
  assign fat_word = {rd_byte, lo_q};
  assign entry    = cl_q[0] ? fat_word[15:4] : (fat_word[11:0] & ENTRY_MASK);
  assign cl_rel   = cl_q - 12'd2;
  assign z_sum    = 21'(prod_q) + 21'(startm1_q);

  fca_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    res_d       = res_q;
    cl_d        = cl_q;
    off_d       = off_q;
    lo_d        = lo_q;
    prod_d      = prod_q;
    startm1_d   = startm1_q;
    z_d         = z_q;
    div_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_d = '0;
          cl_d  = in_i.cluster;
          off_d = rd_off;
          if (in_i.op == OP_WRITE) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RD_HI;
          end
        end
      end
      S_RD_HI: begin
        lo_d    = rd_byte;
        state_d = S_ENTRY;
      end
      S_ENTRY: begin
        res_d.next_cluster = entry;
        res_d.end_of_chain = (entry == '0) || ((entry & EOC_MASK) == EOC_MASK);
        res_d.bad_cluster  = (cl_q < 12'd2);
        prod_d    = 20'(cl_rel) * 20'(spc_q);
        // One less than the data start sector.
        startm1_d = 10'(reserved_q) + 10'(fat_sectors_q) * 10'(fat_count_q)
                    + 10'(root_entries_q >> ROOT_SHIFT);
        if (cl_q < 12'd2) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        z_d     = z_sum[19:0];
        state_d = S_DIV1_GO;
      end
      S_DIV1_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = z_q;
        div_req.divisor  = DIVS_W'(spt_eff);
        res_d.logical_sector = z_q + 20'd1;
        state_d = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (div_rsp.done) begin
          res_d.head   = div_rsp.quotient[0];
          res_d.sector = div_rsp.remainder[5:0] + 6'd1;
          state_d      = S_DIV2_GO;
        end
      end
      S_DIV2_GO: begin
        // floor(floor(z / spt) / heads) equals floor(z / (spt * heads)).
        div_req.start    = 1'b1;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = DIVS_W'(heads_eff);
        state_d = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (div_rsp.done) begin
          res_d.track = div_rsp.quotient;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    out_q     <= out_d;
    cl_q      <= cl_d;
    off_q     <= off_d;
    oor_q     <= (rd_off >= TABLE_END);
    lo_q      <= lo_d;
    prod_q    <= prod_d;
    startm1_q <= startm1_d;
    z_q       <= z_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result word appeared without passing the final state");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV1_WAIT || state_q == S_DIV2_WAIT))
    else $error("divider finished while the sequencer was not waiting for it");

  a_accept_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !div_rsp.busy)
    else $error("input word accepted while a division is running");

  a_bad_cluster_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.bad_cluster) |->
      (out_o.logical_sector == '0 && out_o.track == '0 && out_o.sector == '0))
    else $error("bad cluster result carries a nonzero address");

endmodule

// ----- test/tb_fat12_cluster_chain_address.sv -----
module tb_fat12_cluster_chain_address;
  import fca_pkg::*;

  // Keeps a private copy of the FAT image and the disk geometry, and predicts
  // the result word of every accepted input word.
  class chain_lookup_checker;
    bit [7:0]  fat_image [FAT_TABLE_BYTES_DEF];
    bit [7:0]  rsv_secs;
    bit [4:0]  fat_secs;
    bit [2:0]  fat_copies;
    bit [11:0] root_ents;
    bit [7:0]  clu_secs;
    bit [5:0]  trk_secs;
    bit [7:0]  heads;
    out_word_t lookups_due [$];
    int        fails;

    function new();
      rsv_secs   = 8'd0;
      fat_secs   = 5'd9;
      fat_copies = 3'd2;
      root_ents  = 12'd224;
      clu_secs   = 8'd1;
      trk_secs   = 6'd18;
      heads      = 8'd2;
      fails      = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_RESERVED_SECTORS:    rsv_secs   = v[7:0];
        REG_FAT_SECTORS:         fat_secs   = v[4:0];
        REG_FAT_COUNT:           fat_copies = v[2:0];
        REG_ROOT_ENTRIES:        root_ents  = v[11:0];
        REG_SECTORS_PER_CLUSTER: clu_secs   = v[7:0];
        REG_SECTORS_PER_TRACK:   trk_secs   = v[5:0];
        REG_HEAD_COUNT:          heads      = v[7:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] fat_byte(int unsigned off);
      if (off >= FAT_TABLE_BYTES_DEF) return 8'h00;
      return fat_image[off];
    endfunction

    function out_word_t predict_lookup(in_word_t w);
      out_word_t   r;
      int unsigned c, off, first, lsec, z, spt, hc, per_track;
      int unsigned rsv, fsec, fcnt, roots, spc;
      bit [15:0]   pair;
      r = '0;
      if (w.op == OP_WRITE) begin
        if (w.byte_address < FAT_TABLE_BYTES_DEF) fat_image[w.byte_address] = w.byte_value;
        return r;
      end
      c = 32'(w.cluster);
      off = (c * 3) / 2;
      pair = {fat_byte(off + 1), fat_byte(off)};
      if (w.cluster[0]) pair = pair >> 4;
      r.next_cluster = pair[11:0] & ENTRY_MASK;
      r.end_of_chain = (r.next_cluster == 12'd0) ||
                       ((r.next_cluster & EOC_MASK) == EOC_MASK);
      if (c < 2) begin
        r.bad_cluster = 1'b1;
        return r;
      end
      rsv   = 32'(rsv_secs);
      fsec  = 32'(fat_secs);
      fcnt  = 32'(fat_copies);
      roots = 32'(root_ents);
      spc   = 32'(clu_secs);
      first = rsv + 1 + fsec * fcnt + (roots * DIR_ENTRY_BYTES) / SECTOR_BYTES;
      lsec  = ((c - 2) * spc + first) & 32'h000F_FFFF;
      // A zero sectors-per-track or head-count register counts as one.
      spt = (trk_secs == 0) ? 1 : 32'(trk_secs);
      hc  = (heads == 0) ? 1 : 32'(heads);
      z   = lsec - 1;
      per_track = z / spt;
      r.logical_sector = lsec[19:0];
      r.track          = 20'((z / (spt * hc)) & 32'h000F_FFFF);
      r.head           = per_track[0];
      r.sector         = 6'((1 + z % spt) & 32'h3F);
      return r;
    endfunction

    function void note_word(in_word_t w);
      lookups_due.push_back(predict_lookup(w));
    endfunction

    function void cmp_field(string name, logic [19:0] want, logic [19:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (lookups_due.size() == 0) begin
        $error("result word %h arrived with nothing expected", got);
        fails++;
        return;
      end
      want = lookups_due.pop_front();
      cmp_field("next_cluster", 20'(want.next_cluster), 20'(got.next_cluster));
      cmp_field("end_of_chain", 20'(want.end_of_chain), 20'(got.end_of_chain));
      cmp_field("bad_cluster", 20'(want.bad_cluster), 20'(got.bad_cluster));
      cmp_field("logical_sector", want.logical_sector, got.logical_sector);
      cmp_field("track", want.track, got.track);
      cmp_field("head", 20'(want.head), 20'(got.head));
      cmp_field("sector", 20'(want.sector), 20'(got.sector));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_i        = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  chain_lookup_checker lookups = new();
  bit                  fat_known [FAT_TABLE_BYTES_DEF];
  int unsigned         traced [$];
  int                  n_sent   = 0;
  bit                  calm     = 1'b0;
  bit                  hold_req = 1'b0;

  fat12_cluster_chain_address u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: checks accepted words at the rising edge, picks the next stall
  // value at the falling edge.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) lookups.check_word(out_o);
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 299;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= w;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    lookups.note_word(w);
    if (w.op == OP_WRITE) fat_known[w.byte_address] = 1'b1;
    n_sent++;
  endtask

  task automatic write_fat(int unsigned addr, logic [7:0] val);
    in_word_t w;
    w.op           = OP_WRITE;
    w.byte_address = 13'(addr);
    w.byte_value   = val;
    w.cluster      = 12'($urandom_range(0, 4095));
    send_word(w);
  endtask

  task automatic follow(int unsigned c);
    in_word_t w;
    w.op           = OP_FOLLOW;
    w.byte_address = 13'($urandom_range(0, FAT_TABLE_BYTES_DEF - 1));
    w.byte_value   = 8'($urandom_range(0, 255));
    w.cluster      = 12'(c);
    send_word(w);
    traced.push_back(c);
  endtask

  // Biased toward bytes that build end-of-chain and free entries.
  function automatic logic [7:0] entry_byte();
    case ($urandom_range(0, 5))
      0:       return 8'hFF;
      1:       return 8'hF0;
      2:       return 8'h00;
      3:       return 8'h0F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Fills in whatever bytes of the entry are still unknown, then follows it.
  task automatic trace_cluster(int unsigned c);
    int unsigned off;
    off = (c * 3) / 2;
    for (int k = 0; k < 2; k++) begin
      if (!fat_known[off + k]) write_fat(off + k, entry_byte());
    end
    follow(c);
  endtask

  task automatic random_step();
    int unsigned pick;
    int unsigned c;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      c = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 4095);
      trace_cluster(c);
    end else if (pick < 75 && traced.size() > 0) begin
      follow(traced[$urandom_range(0, traced.size() - 1)]);
    end else if (pick < 85 && traced.size() > 0) begin
      c = traced[$urandom_range(0, traced.size() - 1)];
      write_fat((c * 3) / 2 + $urandom_range(0, 1), entry_byte());
      follow(c);
    end else begin
      write_fat($urandom_range(0, FAT_TABLE_BYTES_DEF - 1), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = n_sent + count;
    while (n_sent < stop_at) random_step();
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lookups.lookups_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lookups.set_reg(idx, v);
  endtask

  task automatic set_geometry(int unsigned rsv, int unsigned fsec, int unsigned fcnt,
                              int unsigned roots, int unsigned spc, int unsigned spt,
                              int unsigned hc);
    write_reg(REG_RESERVED_SECTORS, CFG_DATA_W'(rsv));
    write_reg(REG_FAT_SECTORS, CFG_DATA_W'(fsec));
    write_reg(REG_FAT_COUNT, CFG_DATA_W'(fcnt));
    write_reg(REG_ROOT_ENTRIES, CFG_DATA_W'(roots));
    write_reg(REG_SECTORS_PER_CLUSTER, CFG_DATA_W'(spc));
    write_reg(REG_SECTORS_PER_TRACK, CFG_DATA_W'(spt));
    write_reg(REG_HEAD_COUNT, CFG_DATA_W'(hc));
  endtask

  task automatic random_geometry();
    set_geometry($urandom_range(0, 255), $urandom_range(1, 16), $urandom_range(1, 4),
                 $urandom_range(0, 4095), $urandom_range(1, 128), $urandom_range(1, 63),
                 $urandom_range(1, 255));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reserved entries 0 and 1 with a media descriptor, followed as bad clusters.
    write_fat(0, 8'hF0);
    write_fat(1, 8'hFF);
    write_fat(2, 8'hFF);
    follow(0);
    follow(1);
    // Short chain 2 -> 3 -> 4, then a free entry at 5.
    write_fat(3, 8'h03);
    write_fat(4, 8'h40);
    write_fat(5, 8'h00);
    write_fat(6, 8'h34);
    write_fat(7, 8'h0F);
    write_fat(8, 8'h00);
    follow(2);
    follow(3);
    follow(4);
    follow(5);
    // Top of the cluster range: one entry just below the end-of-chain band,
    // one inside it.
    write_fat(6141, 8'hEF);
    write_fat(6142, 8'h0F);
    write_fat(6143, 8'hFF);
    follow(4094);
    follow(4095);
    write_fat(FAT_TABLE_BYTES_DEF - 1, 8'hFF);
    run_random(60);
    drain();

    // Smallest in-range geometry; the receiver also holds off for a long
    // stretch so the block backs up into its input.
    set_geometry(0, 1, 1, 0, 1, 1, 1);
    hold_req = 1'b1;
    run_random(60);
    drain();

    set_geometry(255, 16, 4, 4095, 128, 63, 255);
    run_random(60);
    drain();

    // Zero geometry registers.
    set_geometry(0, 0, 0, 0, 0, 0, 0);
    run_random(50);
    drain();

    // All-ones data; each register narrower than the data keeps only the low bits.
    set_geometry(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    hold_req = 1'b1;
    run_random(50);
    drain();

    random_geometry();
    run_random(60);
    drain();

    calm = 1'b1;
    random_geometry();
    run_random(60);
    drain();

    if (lookups.fails == 0 && lookups.lookups_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
